// File: design/dsnm_pkg.sv
// shared constants, types and helpers for the diamond-square noise map
package dsnm_pkg;

    localparam int MAX_WIDTH_LOG2  = 8;
    localparam int MAX_HEIGHT_LOG2 = 8;
    localparam int ADDR_W = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2;
    localparam int CRD_W  = ((MAX_WIDTH_LOG2 > MAX_HEIGHT_LOG2) ?
                             MAX_WIDTH_LOG2 : MAX_HEIGHT_LOG2) + 1;
    localparam int LOG_W  = 4;
    localparam int LVL_W  = 3;

    localparam int MT_N     = 624;
    localparam int MT_M     = 397;
    localparam int MT_IDX_W = 10;
    localparam logic [31:0] MT_MULT = 32'd1812433253;
    localparam logic [31:0] MT_MAT  = 32'h9908b0df;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED    = 3'd4;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [LOG_W-1:0] RST_WIDTH_LOG2  = 4'd8;
    localparam logic [LOG_W-1:0] RST_HEIGHT_LOG2 = 4'd8;
    localparam logic [LVL_W-1:0] RST_LEVELS      = 3'd0;
    localparam logic [31:0]      RST_RNG_SEED    = 32'd5489;

    // sequencer to twister
    typedef struct packed {
        logic seed_start;
        logic draw_req;
    } t_mt_ctl;

    // twister to sequencer
    typedef struct packed {
        logic ready;
        logic draw_valid;
    } t_mt_stat;

    // map address of a wrapped cell
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [CRD_W-1:0] cx,
        input logic [CRD_W-1:0] cy,
        input logic [LOG_W-1:0] wl,
        input logic [LOG_W-1:0] hl
    );
        logic [CRD_W-1:0]  wm;
        logic [CRD_W-1:0]  hm;
        logic [ADDR_W-1:0] xa;
        logic [ADDR_W-1:0] ya;
        wm = ~({CRD_W{1'b1}} << wl);
        hm = ~({CRD_W{1'b1}} << hl);
        xa = ADDR_W'(cx & wm);
        ya = ADDR_W'(cy & hm) << wl;
        return xa | ya;
    endfunction

endpackage

// File: design/dsnm_twister.sv
// mt19937 generator: sequential seeding and one lazily twisted word per draw
module dsnm_twister (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsnm_pkg::t_mt_ctl    i_ctl,
    input  logic [31:0]          i_seed,
    output dsnm_pkg::t_mt_stat   o_stat,
    output logic [31:0]          o_rand
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_XOR,
        S_SEED_MUL,
        S_SEED_ADD,
        S_D0,
        S_D1,
        S_D2,
        S_D3
    } t_state;

    t_state r_state;
    logic [dsnm_pkg::MT_IDX_W-1:0] r_idx;
    logic [31:0] r_prev;
    logic [31:0] r_x;
    logic [31:0] r_prod;
    logic [31:0] r_si;
    logic [31:0] r_si1;
    logic [31:0] r_q;
    logic [31:0] r_rand;
    logic        r_draw_valid;

    logic [31:0] mem [0:dsnm_pkg::MT_N-1];

    logic                          we;
    logic [dsnm_pkg::MT_IDX_W-1:0] waddr;
    logic [31:0]                   wdata;
    logic [dsnm_pkg::MT_IDX_W-1:0] raddr;
    logic [dsnm_pkg::MT_IDX_W-1:0] idx_nx;
    logic [dsnm_pkg::MT_IDX_W:0]   idx_m_sum;
    logic [dsnm_pkg::MT_IDX_W-1:0] idx_m;
    logic [31:0]                   seed_val;
    logic [31:0]                   twist_v;
    logic [31:0]                   twist_n;

    function automatic logic [31:0] temper(input logic [31:0] v);
        logic [31:0] y;
        y = v;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    always_comb begin
        idx_nx = (r_idx == dsnm_pkg::MT_IDX_W'(dsnm_pkg::MT_N - 1)) ? '0
                 : r_idx + 1'b1;
        idx_m_sum = {1'b0, r_idx} + (dsnm_pkg::MT_IDX_W + 1)'(dsnm_pkg::MT_M);
        idx_m = (idx_m_sum >= (dsnm_pkg::MT_IDX_W + 1)'(dsnm_pkg::MT_N))
                ? dsnm_pkg::MT_IDX_W'(idx_m_sum - (dsnm_pkg::MT_IDX_W + 1)'(dsnm_pkg::MT_N))
                : dsnm_pkg::MT_IDX_W'(idx_m_sum);
        seed_val = r_prod + 32'(r_idx);
        twist_v  = {r_si[31], r_si1[30:0]};
        twist_n  = r_q ^ (twist_v >> 1) ^ (twist_v[0] ? dsnm_pkg::MT_MAT : 32'd0);
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = seed_val;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.seed_start) begin
                    we    = 1'b1;
                    waddr = '0;
                    wdata = i_seed;
                end
            end
            S_SEED_ADD: we = 1'b1;
            S_D3: begin
                we    = 1'b1;
                wdata = twist_n;
            end
            default: we = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_D1:    raddr = idx_nx;
            S_D2:    raddr = idx_m;
            default: raddr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_q <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_draw_valid <= 1'b0;
        end else begin
            r_draw_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.seed_start) begin
                        r_prev  <= i_seed;
                        r_idx   <= dsnm_pkg::MT_IDX_W'(1);
                        r_state <= S_SEED_XOR;
                    end else if (i_ctl.draw_req) begin
                        r_state <= S_D0;
                    end
                end
                S_SEED_XOR: begin
                    r_x     <= r_prev ^ (r_prev >> 30);
                    r_state <= S_SEED_MUL;
                end
                S_SEED_MUL: begin
                    r_prod  <= r_x * dsnm_pkg::MT_MULT;
                    r_state <= S_SEED_ADD;
                end
                S_SEED_ADD: begin
                    r_prev <= seed_val;
                    if (r_idx == dsnm_pkg::MT_IDX_W'(dsnm_pkg::MT_N - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SEED_XOR;
                    end
                end
                S_D0: r_state <= S_D1;
                S_D1: begin
                    r_si    <= r_q;
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_si1   <= r_q;
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_rand       <= temper(twist_n);
                    r_draw_valid <= 1'b1;
                    r_idx        <= idx_nx;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.ready      = (r_state == S_IDLE);
    assign o_stat.draw_valid = r_draw_valid;
    assign o_rand            = r_rand;

endmodule

// File: design/diamond_square_noise_map.sv
// diamond-square noise map: sequencer, map memory and twister hookup
// read: item accepted in idle, then the issue, capture and hand-off states register the result
// generate: clears all 2^(MAX_WIDTH_LOG2+MAX_HEIGHT_LOG2) map words, then visits the cells
//   at a pace set by the single map read port and the twister draw
// no new item is taken until the result has been loaded into the output register
// reset (synchronous, active low) clears control state; map reads return 128, as for a stored
//   zero, until the first generate through the map-valid flag
module diamond_square_noise_map (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [7:0]                          i_cell_x,
    input  logic [7:0]                          i_cell_y,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_cell_value,
    output logic                                o_gen_done,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dsnm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    localparam int CW = dsnm_pkg::CRD_W;
    localparam int AW = dsnm_pkg::ADDR_W;
    localparam int LW = dsnm_pkg::LOG_W;
    localparam int VW = dsnm_pkg::LVL_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_RD_CAP,
        S_CLEAR,
        S_MT_WAIT,
        S_SEED_DRAW,
        S_SEED_WAIT,
        S_SEED_DRAW2,
        S_SEED_WAIT2,
        S_SEED_MOD,
        S_DIA_RD,
        S_DIA_CAP,
        S_DIA_SUM,
        S_DIA_DRAW,
        S_DIA_WAIT,
        S_DIA_ZERO,
        S_SQ_RD,
        S_SQ_CAP,
        S_SQ_SUM,
        S_SQ_DRAW1,
        S_SQ_WAIT1,
        S_SQ_DRAW2,
        S_SQ_WAIT2,
        S_OUT
    } t_state;

    // configuration registers
    logic [LW-1:0] r_cfg_wl;
    logic [LW-1:0] r_cfg_hl;
    logic [VW-1:0] r_cfg_lv;
    logic          r_cfg_edge;
    logic [31:0]   r_cfg_seed;

    // geometry of the last generate
    logic [LW-1:0] r_wl;
    logic [LW-1:0] r_hl;
    logic [VW-1:0] r_lv;
    logic          r_edge;
    logic          r_map_valid;

    // sequencer
    t_state        r_state;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    logic [CW-1:0] r_step;
    logic [2:0]    r_k;
    logic [31:0]   r_op [0:5];
    logic [31:0]   r_sum;
    logic [5:0]    r_csum;
    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_cx;
    logic [CW-1:0] r_cy;
    logic [31:0]   r_res_value;
    logic          r_res_done;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic               r_out_done;

    // map memory
    logic [31:0] map_mem [0:(1 << AW)-1];
    logic [31:0] r_mem_q;

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [LW-1:0] wl_clamp;
    logic [LW-1:0] hl_clamp;
    logic [VW-1:0] lv_clamp;
    logic [CW-1:0] w_sz;
    logic [CW-1:0] h_sz;
    logic [CW-1:0] half;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic          wrap_x;
    logic          grid_last;
    logic [CW-1:0] rd_x;
    logic [CW-1:0] rd_y;
    logic [31:0]   amp;
    logic [31:0]   jit;
    logic [31:0]   sum_a;
    logic [31:0]   sum_b;
    logic [31:0]   sum_c;
    logic [31:0]   sum_d;
    logic [31:0]   sum4;
    logic [31:0]   seed_plain;
    logic [31:0]   seed_inner;
    logic [31:0]   rd_value;
    logic          edge_line;
    logic [CW-1:0] step_nx;

    dsnm_pkg::t_mt_ctl  mt_ctl;
    dsnm_pkg::t_mt_stat mt_stat;
    logic [31:0]        mt_rand;

    // signed divide by four, truncating toward zero
    function automatic logic [31:0] avg4(input logic [31:0] s);
        logic [31:0] t;
        t = s + (s[31] ? 32'd3 : 32'd0);
        return {{2{t[31]}}, t[31:2]};
    endfunction

    // sum of the 2-bit digits of r[31:6]; congruent to r >> 6 mod 3
    function automatic logic [5:0] digit_sum(input logic [31:0] r);
        logic [5:0] s;
        s = '0;
        for (int i = 0; i < 13; i++) begin
            s = s + 6'(r[6 + 2*i +: 2]);
        end
        return s;
    endfunction

    function automatic logic [1:0] mod3(input logic [5:0] s);
        logic [3:0] t;
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        if (t >= 4'd6) t = t - 4'd6;
        if (t >= 4'd3) t = t - 4'd3;
        return t[1:0];
    endfunction

    dsnm_twister u_twister (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mt_ctl),
        .i_seed  (r_cfg_seed),
        .o_stat  (mt_stat),
        .o_rand  (mt_rand)
    );

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // clamp the geometry registers as a generate latches them
    always_comb begin
        if (r_cfg_wl == '0) begin
            wl_clamp = LW'(1);
        end else if (r_cfg_wl > LW'(dsnm_pkg::MAX_WIDTH_LOG2)) begin
            wl_clamp = LW'(dsnm_pkg::MAX_WIDTH_LOG2);
        end else begin
            wl_clamp = r_cfg_wl;
        end
        if (r_cfg_hl == '0) begin
            hl_clamp = LW'(1);
        end else if (r_cfg_hl > LW'(dsnm_pkg::MAX_HEIGHT_LOG2)) begin
            hl_clamp = LW'(dsnm_pkg::MAX_HEIGHT_LOG2);
        end else begin
            hl_clamp = r_cfg_hl;
        end
        lv_clamp = (LW'(r_cfg_lv) < wl_clamp) ? r_cfg_lv : VW'(wl_clamp - 1'b1);
    end

    // grid walk: x fastest, then y, in steps of the current pitch
    always_comb begin
        w_sz      = CW'(1) << r_wl;
        h_sz      = CW'(1) << r_hl;
        half      = r_step >> 1;
        step_nx   = r_step >> 1;
        nx        = r_x + r_step;
        ny        = r_y + r_step;
        wrap_x    = (nx >= w_sz);
        grid_last = wrap_x && (ny >= h_sz);
        edge_line = r_edge && ((r_x == '0) || (r_y == '0));
    end

    // jitter amplitude is 256 * (step << levels), always a power of two
    always_comb begin
        amp = (32'(r_step) << r_lv) << 8;
        jit = (mt_rand & ((amp << 1) - 32'd1)) - amp;
    end

    // shared four-input adder for the diamond and both square averages
    always_comb begin
        sum_a = r_op[0];
        sum_b = r_op[1];
        sum_c = r_op[2];
        sum_d = r_op[3];
        case (r_state)
            S_SQ_SUM: begin
                sum_c = r_op[5];
                sum_d = r_op[3];
            end
            S_SQ_WAIT1: begin
                sum_b = r_op[2];
                sum_c = r_op[5];
                sum_d = r_op[4];
            end
            default: sum_a = r_op[0];
        endcase
        sum4 = sum_a + sum_b + sum_c + sum_d;
    end

    // seed values: plain byte range, or the narrower interior range in edge mode
    always_comb begin
        seed_plain = (32'(mt_rand[7:0]) - 32'd128) << 4;
        seed_inner = (32'({mod3(r_csum), mt_rand[5:0]}) - 32'd64) << 4;
    end

    // read result: truncating divide by 512 plus 128, or 128 before any map exists
    always_comb begin
        logic [31:0] t;
        t        = r_mem_q + (r_mem_q[31] ? 32'd511 : 32'd0);
        rd_value = {{9{t[31]}}, t[31:9]} + 32'd128;
        if (!r_map_valid) begin
            rd_value = 32'd128;
        end
    end

    // neighbor coordinates for the current read slot
    always_comb begin
        rd_x = r_x;
        rd_y = r_y;
        if (r_state == S_DIA_RD) begin
            case (r_k)
                3'd1:    rd_y = r_y + r_step;
                3'd2:    rd_x = r_x + r_step;
                3'd3: begin
                    rd_x = r_x + r_step;
                    rd_y = r_y + r_step;
                end
                default: rd_x = r_x;
            endcase
        end else begin
            case (r_k)
                3'd1:    rd_x = r_x + r_step;
                3'd2:    rd_y = r_y + r_step;
                3'd3: begin
                    rd_x = r_x + half;
                    rd_y = r_y + half - r_step;
                end
                3'd4: begin
                    rd_x = r_x + half - r_step;
                    rd_y = r_y + half;
                end
                3'd5: begin
                    rd_x = r_x + half;
                    rd_y = r_y + half;
                end
                default: rd_x = r_x;
            endcase
        end
    end

    always_comb begin
        if (r_state == S_RD_ISSUE) begin
            mem_raddr = dsnm_pkg::cell_addr(r_cx, r_cy, r_wl, r_hl);
        end else begin
            mem_raddr = dsnm_pkg::cell_addr(rd_x, rd_y, r_wl, r_hl);
        end
    end

    // single map write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = dsnm_pkg::cell_addr(r_x, r_y, r_wl, r_hl);
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_SEED_WAIT: begin
                if (mt_stat.draw_valid) begin
                    if (!r_edge) begin
                        mem_we    = 1'b1;
                        mem_wdata = seed_plain;
                    end else if (edge_line) begin
                        mem_we = 1'b1;
                    end
                end
            end
            S_SEED_MOD: begin
                mem_we    = 1'b1;
                mem_wdata = seed_inner;
            end
            S_DIA_WAIT: begin
                mem_we    = mt_stat.draw_valid;
                mem_waddr = dsnm_pkg::cell_addr(r_x + half, r_y + half, r_wl, r_hl);
                mem_wdata = avg4(r_sum) + jit;
            end
            S_DIA_ZERO: mem_we = 1'b1;
            S_SQ_WAIT1: begin
                mem_we    = mt_stat.draw_valid;
                mem_waddr = dsnm_pkg::cell_addr(r_x + half, r_y, r_wl, r_hl);
                mem_wdata = avg4(r_sum) + jit;
            end
            S_SQ_WAIT2: begin
                mem_we    = mt_stat.draw_valid;
                mem_waddr = dsnm_pkg::cell_addr(r_x, r_y + half, r_wl, r_hl);
                mem_wdata = avg4(r_sum) + jit;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= map_mem[mem_raddr];
    end

    // twister draw requests come straight from the sequencer state; seeding starts on an accepted generate
    always_comb begin
        mt_ctl.seed_start = accept && (i_opcode == dsnm_pkg::OP_GENERATE);
        mt_ctl.draw_req   = (r_state == S_SEED_DRAW) || (r_state == S_SEED_DRAW2) ||
                            (r_state == S_DIA_DRAW) || (r_state == S_SQ_DRAW1) ||
                            (r_state == S_SQ_DRAW2);
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wl   <= dsnm_pkg::RST_WIDTH_LOG2;
            r_cfg_hl   <= dsnm_pkg::RST_HEIGHT_LOG2;
            r_cfg_lv   <= dsnm_pkg::RST_LEVELS;
            r_cfg_edge <= 1'b0;
            r_cfg_seed <= dsnm_pkg::RST_RNG_SEED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dsnm_pkg::REG_WIDTH_LOG2:  r_cfg_wl   <= i_cfg_data[LW-1:0];
                dsnm_pkg::REG_HEIGHT_LOG2: r_cfg_hl   <= i_cfg_data[LW-1:0];
                dsnm_pkg::REG_LEVELS:      r_cfg_lv   <= i_cfg_data[VW-1:0];
                dsnm_pkg::REG_EDGE_MODE:   r_cfg_edge <= i_cfg_data[0];
                dsnm_pkg::REG_RNG_SEED:    r_cfg_seed <= i_cfg_data;
                default:                   r_cfg_wl   <= r_cfg_wl;
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_wl        <= dsnm_pkg::RST_WIDTH_LOG2;
            r_hl        <= dsnm_pkg::RST_HEIGHT_LOG2;
            r_lv        <= dsnm_pkg::RST_LEVELS;
            r_edge      <= 1'b0;
            r_k         <= '0;
            r_clr       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cx <= CW'(i_cell_x);
                        r_cy <= CW'(i_cell_y);
                        if (i_opcode == dsnm_pkg::OP_READ) begin
                            r_state <= S_RD_ISSUE;
                        end else begin
                            // latch geometry, then sweep the map clear
                            r_wl    <= wl_clamp;
                            r_hl    <= hl_clamp;
                            r_lv    <= lv_clamp;
                            r_edge  <= r_cfg_edge;
                            r_clr   <= '0;
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_RD_ISSUE: r_state <= S_RD_CAP;
                S_RD_CAP: begin
                    r_res_value <= rd_value;
                    r_res_done  <= r_map_valid;
                    r_state     <= S_OUT;
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {AW{1'b1}}) begin
                        r_step  <= w_sz >> r_lv;
                        r_x     <= '0;
                        r_y     <= '0;
                        r_state <= S_MT_WAIT;
                    end
                end
                S_MT_WAIT: begin
                    if (mt_stat.ready) begin
                        r_state <= S_SEED_DRAW;
                    end
                end
                // seed grid: one draw per cell, a second on interior cells in edge mode
                S_SEED_DRAW: r_state <= S_SEED_WAIT;
                S_SEED_WAIT: begin
                    if (mt_stat.draw_valid) begin
                        if (r_edge && !edge_line) begin
                            r_state <= S_SEED_DRAW2;
                        end else if (grid_last) begin
                            r_x     <= '0;
                            r_y     <= '0;
                            r_k     <= '0;
                            r_state <= S_DIA_RD;
                        end else begin
                            r_x     <= wrap_x ? '0 : nx;
                            r_y     <= wrap_x ? ny : r_y;
                            r_state <= S_SEED_DRAW;
                        end
                    end
                end
                S_SEED_DRAW2: r_state <= S_SEED_WAIT2;
                S_SEED_WAIT2: begin
                    if (mt_stat.draw_valid) begin
                        r_csum  <= digit_sum(mt_rand);
                        r_state <= S_SEED_MOD;
                    end
                end
                S_SEED_MOD: begin
                    if (grid_last) begin
                        r_x     <= '0;
                        r_y     <= '0;
                        r_k     <= '0;
                        r_state <= S_DIA_RD;
                    end else begin
                        r_x     <= wrap_x ? '0 : nx;
                        r_y     <= wrap_x ? ny : r_y;
                        r_state <= S_SEED_DRAW;
                    end
                end
                // diamond pass: four corners, center gets average plus jitter; edge mode zeroes edge cells
                S_DIA_RD: r_state <= S_DIA_CAP;
                S_DIA_CAP: begin
                    r_op[r_k] <= r_mem_q;
                    if (r_k == 3'd3) begin
                        r_state <= S_DIA_SUM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DIA_RD;
                    end
                end
                S_DIA_SUM: begin
                    r_sum   <= sum4;
                    r_state <= S_DIA_DRAW;
                end
                S_DIA_DRAW: r_state <= S_DIA_WAIT;
                S_DIA_WAIT: begin
                    if (mt_stat.draw_valid) begin
                        r_state <= S_DIA_ZERO;
                        if (!edge_line) begin
                            r_k <= '0;
                            if (grid_last) begin
                                r_x     <= '0;
                                r_y     <= '0;
                                r_state <= S_SQ_RD;
                            end else begin
                                r_x     <= wrap_x ? '0 : nx;
                                r_y     <= wrap_x ? ny : r_y;
                                r_state <= S_DIA_RD;
                            end
                        end
                    end
                end
                S_DIA_ZERO: begin
                    r_k <= '0;
                    if (grid_last) begin
                        r_x     <= '0;
                        r_y     <= '0;
                        r_state <= S_SQ_RD;
                    end else begin
                        r_x     <= wrap_x ? '0 : nx;
                        r_y     <= wrap_x ? ny : r_y;
                        r_state <= S_DIA_RD;
                    end
                end
                // square pass: six reads, then top and left edge midpoints
                S_SQ_RD: r_state <= S_SQ_CAP;
                S_SQ_CAP: begin
                    r_op[r_k] <= r_mem_q;
                    if (r_k == 3'd5) begin
                        r_state <= S_SQ_SUM;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_SQ_RD;
                    end
                end
                S_SQ_SUM: begin
                    r_sum   <= sum4;
                    r_state <= S_SQ_DRAW1;
                end
                S_SQ_DRAW1: r_state <= S_SQ_WAIT1;
                S_SQ_WAIT1: begin
                    if (mt_stat.draw_valid) begin
                        r_sum   <= sum4;
                        r_state <= S_SQ_DRAW2;
                    end
                end
                S_SQ_DRAW2: r_state <= S_SQ_WAIT2;
                S_SQ_WAIT2: begin
                    if (mt_stat.draw_valid) begin
                        r_k <= '0;
                        if (grid_last) begin
                            r_x    <= '0;
                            r_y    <= '0;
                            r_step <= step_nx;
                            if (step_nx > CW'(1)) begin
                                r_state <= S_DIA_RD;
                            end else begin
                                r_map_valid <= 1'b1;
                                r_res_value <= '0;
                                r_res_done  <= 1'b1;
                                r_state     <= S_OUT;
                            end
                        end else begin
                            r_x     <= wrap_x ? '0 : nx;
                            r_y     <= wrap_x ? ny : r_y;
                            r_state <= S_SQ_RD;
                        end
                    end
                end
                // hand the result to the output register once it is free
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_done  <= r_res_done;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;
    assign o_gen_done   = r_out_done;

`ifndef SYNTHESIS
    // one item at a time: the block closes right after taking an item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while a previous one is in flight");

    // a result appears only from the hand-off state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside hand-off");

    // every random word lands in a state that consumes it
    a_draw_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mt_stat.draw_valid |-> (r_state == S_SEED_WAIT || r_state == S_SEED_WAIT2 ||
                                r_state == S_DIA_WAIT || r_state == S_SQ_WAIT1 ||
                                r_state == S_SQ_WAIT2))
        else $error("random word dropped");

    // draws are only requested from an idle twister
    a_draw_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mt_ctl.draw_req |-> mt_stat.ready)
        else $error("draw requested while twister busy");
`endif

endmodule

// File: tb/tb.sv
// self-checking testbench for the diamond-square noise map: generate and read items
module tb;
    import dsnm_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] x;
        logic [7:0] y;
    } cmd_t;

    typedef struct {
        logic [31:0] value;
        logic        done;
    } cell_res_t;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // block ports; the inputs are driven known from time zero
    logic                 in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 opcode    = OP_READ;
    logic [7:0]           cell_x    = '0;
    logic [7:0]           cell_y    = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    logic signed [31:0]   o_cell_value;
    logic                 o_gen_done;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    diamond_square_noise_map dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (opcode),
        .i_cell_x     (cell_x),
        .i_cell_y     (cell_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_cell_value (o_cell_value),
        .o_gen_done   (o_gen_done),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor state: its own register copy, twister and height map
    // ------------------------------------------------------------------
    logic [3:0]  m_wl_reg   = RST_WIDTH_LOG2;
    logic [3:0]  m_hl_reg   = RST_HEIGHT_LOG2;
    logic [2:0]  m_levels   = RST_LEVELS;
    logic        m_edge     = 1'b0;
    logic [31:0] m_seed     = RST_RNG_SEED;
    int unsigned map_wl     = MAX_WIDTH_LOG2;   // geometry of the last generate
    int unsigned map_hl     = MAX_HEIGHT_LOG2;
    logic        map_built  = 1'b0;
    logic [31:0] heights [0:(1<<ADDR_W)-1];
    logic [31:0] tw_state [0:MT_N-1];
    int unsigned tw_pos;

    cmd_t      pending_cmds [$];
    cell_res_t expected_cells [$];
    int        n_errors  = 0;
    int        n_results = 0;

    function automatic int unsigned clamp_exp(logic [3:0] v, int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void twister_seed(logic [31:0] s);
        logic [31:0] p;
        tw_state[0] = s;
        for (int i = 1; i < MT_N; i++) begin
            p = tw_state[i-1];
            tw_state[i] = MT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        tw_pos = MT_N;
    endfunction

    function automatic logic [31:0] twister_draw();
        logic [31:0] v;
        logic [31:0] n;
        logic [31:0] y;
        if (tw_pos >= MT_N) begin
            for (int i = 0; i < MT_N; i++) begin
                v = (tw_state[i] & 32'h8000_0000) | (tw_state[(i+1)%MT_N] & 32'h7fff_ffff);
                n = tw_state[(i+MT_M)%MT_N] ^ (v >> 1);
                if (v[0]) n = n ^ MT_MAT;
                tw_state[i] = n;
            end
            tw_pos = 0;
        end
        y = tw_state[tw_pos];
        tw_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // wrapped cell address in the current geometry
    function automatic int unsigned cell_at(int unsigned x, int unsigned y);
        return (x & ((1 << map_wl) - 1)) + ((y & ((1 << map_hl) - 1)) << map_wl);
    endfunction

    // truncating average with a wrapping 32-bit sum
    function automatic logic [31:0] mean4(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
        logic signed [31:0] s;
        s = $signed(a + b + c + d);
        return s / 4;
    endfunction

    function automatic logic [31:0] jitter(logic [31:0] amp);
        logic [31:0] r;
        r = twister_draw();
        return r % (amp * 2) - amp;
    endfunction

    function automatic void build_height_map();
        int unsigned w, h, lv, step, half;
        logic [31:0] amp, r, a, b, c, d, e, f, top, left;
        map_wl = clamp_exp(m_wl_reg, MAX_WIDTH_LOG2);
        map_hl = clamp_exp(m_hl_reg, MAX_HEIGHT_LOG2);
        w  = 1 << map_wl;
        h  = 1 << map_hl;
        lv = (m_levels < map_wl) ? m_levels : map_wl - 1;
        for (int i = 0; i < (1 << ADDR_W); i++) heights[i] = '0;
        twister_seed(m_seed);

        // seed grid, edge mode zeroes row 0 and column 0
        step = w >> lv;
        for (int unsigned y = 0; y < h; y += step) begin
            for (int unsigned x = 0; x < w; x += step) begin
                r = twister_draw();
                heights[cell_at(x, y)] = (r % 256 - 32'd128) * 32'd16;
                if (m_edge) begin
                    if (x != 0 && y != 0) begin
                        r = twister_draw();
                        heights[cell_at(x, y)] = (r % 192 - 32'd64) * 32'd16;
                    end else begin
                        heights[cell_at(x, y)] = '0;
                    end
                end
            end
        end

        for (step = w >> lv; step > 1; step >>= 1) begin
            amp  = 32'd256 * 32'(step << lv);
            half = step >> 1;
            // diamond pass
            for (int unsigned y = 0; y < h; y += step) begin
                for (int unsigned x = 0; x < w; x += step) begin
                    a = mean4(heights[cell_at(x, y)], heights[cell_at(x, y + step)],
                              heights[cell_at(x + step, y)],
                              heights[cell_at(x + step, y + step)]);
                    heights[cell_at(x + half, y + half)] = a + jitter(amp);
                    if (m_edge && (x == 0 || y == 0)) heights[cell_at(x, y)] = '0;
                end
            end
            // square pass, neighbors behind the origin wrap around the torus
            for (int unsigned y = 0; y < h; y += step) begin
                for (int unsigned x = 0; x < w; x += step) begin
                    a = heights[cell_at(x, y)];
                    b = heights[cell_at(x + step, y)];
                    c = heights[cell_at(x, y + step)];
                    d = heights[cell_at(x + half, y + half - step)];
                    e = heights[cell_at(x + half - step, y + half)];
                    f = heights[cell_at(x + half, y + half)];
                    top  = mean4(a, b, f, d) + jitter(amp);
                    left = mean4(a, c, f, e) + jitter(amp);
                    heights[cell_at(x + half, y)] = top;
                    heights[cell_at(x, y + half)] = left;
                end
            end
        end
        map_built = 1'b1;
    endfunction

    function automatic cell_res_t predict_cell(cmd_t c);
        cell_res_t res;
        logic signed [31:0] v;
        if (c.op == OP_GENERATE) begin
            build_height_map();
            res.value = '0;
            res.done  = 1'b1;
        end else begin
            v = $signed(heights[cell_at(c.x, c.y)]) / 512;
            res.value = v + 32'd128;
            res.done  = map_built;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of items with random gaps between them
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : driver
        logic next_valid;
        cmd_t cur;
        cmd_t nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && !o_in_stall) begin
                // item taken at this edge
                cur.op = opcode;
                cur.x  = cell_x;
                cur.y  = cell_y;
                expected_cells.push_back(predict_cell(cur));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    opcode <= nxt.op;
                    cell_x <= nxt.x;
                    cell_y <= nxt.y;
                    next_valid = 1'b1;
                    if (burst_left == 0) burst_left = $urandom_range(1, 16);
                    burst_left--;
                    // gap only at the end of a burst, sometimes none at all
                    if (burst_left == 0 && $urandom_range(0, 2) != 0)
                        gap_left = $urandom_range(1, 7);
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern and result check
    // ------------------------------------------------------------------
    int  hold_left  = 0;
    bit  hold_taken = 0;
    int  mode_left  = 0;
    bit  choppy     = 0;

    always @(posedge i_clk) begin : receiver
        logic next_stall;
        cell_res_t exp_res;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_results++;
                if (expected_cells.size() == 0) begin
                    $error("unexpected result: cell_value %0d gen_done %0b",
                           o_cell_value, o_gen_done);
                    n_errors++;
                end else begin
                    exp_res = expected_cells.pop_front();
                    if (o_cell_value !== exp_res.value) begin
                        $error("cell_value expected %0d actual %0d",
                               $signed(exp_res.value), o_cell_value);
                        n_errors++;
                    end
                    if (o_gen_done !== exp_res.done) begin
                        $error("gen_done expected %0b actual %0b", exp_res.done, o_gen_done);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the sender backs up against a full block
            if (hold_left > 0) begin
                hold_left--;
                next_stall = 1'b1;
            end else if (!hold_taken && n_results >= 200) begin
                hold_taken = 1;
                hold_left  = 400;
                next_stall = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    choppy    = $urandom_range(0, 1);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                next_stall = choppy && ($urandom_range(0, 2) == 0);
            end
            out_stall <= next_stall;
        end
    end

    // ------------------------------------------------------------------
    // configuration writes, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH_LOG2:  m_wl_reg = data[3:0];
            REG_HEIGHT_LOG2: m_hl_reg = data[3:0];
            REG_LEVELS:      m_levels = data[2:0];
            REG_EDGE_MODE:   m_edge   = data[0];
            REG_RNG_SEED:    m_seed   = data;
            default: ;       // no such register, write dropped
        endcase
    endtask

    task automatic push_cmd(logic op, logic [7:0] x, logic [7:0] y);
        cmd_t c;
        c.op = op;
        c.x  = x;
        c.y  = y;
        pending_cmds.push_back(c);
    endtask

    // sender pauses here until every expected result is back; sampled
    // mid-cycle so the driver's updates at the edge are settled
    task automatic drain();
        do @(negedge i_clk);
        while (pending_cmds.size() > 0 || in_valid || expected_cells.size() > 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic map_phase(logic [3:0] wl, logic [3:0] hl, logic [2:0] lv,
                             logic edge_on, logic [31:0] seed, int n_reads);
        write_reg(REG_WIDTH_LOG2, 32'(wl));
        write_reg(REG_HEIGHT_LOG2, 32'(hl));
        write_reg(REG_LEVELS, 32'(lv));
        write_reg(REG_EDGE_MODE, 32'(edge_on));
        write_reg(REG_RNG_SEED, seed);
        push_cmd(OP_GENERATE, $urandom, $urandom);
        // corners of the byte range, then random cells that wrap onto the map
        push_cmd(OP_READ, 8'h00, 8'h00);
        push_cmd(OP_READ, 8'hff, 8'hff);
        push_cmd(OP_READ, 8'hff, 8'h00);
        push_cmd(OP_READ, 8'h00, 8'hff);
        for (int i = 0; i < n_reads; i++)
            push_cmd(OP_READ, $urandom, $urandom);
        drain();
    endtask

    initial begin
        // the store reads zero until the first generate
        for (int i = 0; i < (1 << ADDR_W); i++) heights[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads before any map exists: zero store, map flag low
        push_cmd(OP_READ, 8'h00, 8'h00);
        push_cmd(OP_READ, 8'hff, 8'hff);
        push_cmd(OP_READ, 8'h5a, 8'ha5);
        drain();

        // smallest map, then the clamped extremes of each register
        map_phase(4'd1, 4'd1, 3'd0, 1'b0, 32'd0, 60);
        map_phase(4'd15, 4'd1, 3'd7, 1'b1, 32'hffff_ffff, 140);
        map_phase(4'd0, 4'd15, 3'd0, 1'b0, $urandom, 140);
        write_reg(3'd5, $urandom);         // beyond the list: ignored
        write_reg(3'd7, $urandom);
        map_phase(4'd8, 4'd1, 3'd0, 1'b0, RST_RNG_SEED, 140);
        map_phase(4'd4, 4'd2, 3'd3, 1'b1, $urandom, 140);
        map_phase(4'd3, 4'd5, 3'd1, 1'b0, $urandom, 140);
        map_phase(4'd4, 4'd4, 3'd2, 1'b1, $urandom, 140);
        map_phase(4'd2, 4'd6, 3'd0, 1'b1, $urandom, 140);
        map_phase(4'd5, 4'd3, 3'd4, 1'b0, $urandom, 140);

        // registers moved after a generate: reads keep the old geometry
        write_reg(REG_WIDTH_LOG2, 32'd2);
        write_reg(REG_HEIGHT_LOG2, 32'd7);
        for (int i = 0; i < 40; i++) push_cmd(OP_READ, $urandom, $urandom);
        drain();

        if (n_errors == 0 && expected_cells.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: diamond_square_noise_map.f
design/dsnm_pkg.sv
design/dsnm_twister.sv
design/diamond_square_noise_map.sv
tb/tb.sv
